FILE: rtl/lcc_pkg.sv
// Shared constants, operation codes and the token type of the leader color clustering block.
package lcc_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int CMP_W       = (IDX_W > 8) ? IDX_W : 8;
	localparam int CH_W        = 8;
	localparam int SLOT_W      = 8;
	localparam int RS_W        = 8;
	localparam int OP_W        = 2;
	localparam int THR_W       = 9;
	localparam int THR2_W      = 2 * THR_W;
	localparam int OUT_CNT_W   = 9;
	localparam int THR_RESET   = 255;

	localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
	localparam logic [OP_W-1:0] OP_CLUSTER = 2'd1;
	localparam logic [OP_W-1:0] OP_READ    = 2'd2;

	// One request as it travels down the cell chain, with its result so far
	typedef struct packed {
		logic              valid;
		logic [OP_W-1:0]   op;
		logic [CH_W-1:0]   red;
		logic [CH_W-1:0]   green;
		logic [CH_W-1:0]   blue;
		logic [RS_W-1:0]   read_slot;
		logic              done;
		logic              merged;
		logic              appended;
		logic [SLOT_W-1:0] slot;
		logic [CH_W-1:0]   res_red;
		logic [CH_W-1:0]   res_green;
		logic [CH_W-1:0]   res_blue;
		logic [CNT_W-1:0]  count;
	} token_t;

endpackage

FILE: rtl/lcc_in_if.sv
// Request channel of the leader color clustering block.
interface lcc_in_if import lcc_pkg::*;;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [CH_W-1:0]   red;
	logic [CH_W-1:0]   green;
	logic [CH_W-1:0]   blue;
	logic [RS_W-1:0]   read_slot;

	modport source (output valid, operation, red, green, blue, read_slot, input ready);
	modport sink (input valid, operation, red, green, blue, read_slot, output ready);
endinterface

FILE: rtl/lcc_out_if.sv
// Result channel of the leader color clustering block.
interface lcc_out_if import lcc_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [SLOT_W-1:0]    slot;
	logic                 merged;
	logic                 appended;
	logic                 dropped;
	logic [CH_W-1:0]      entry_red;
	logic [CH_W-1:0]      entry_green;
	logic [CH_W-1:0]      entry_blue;
	logic [OUT_CNT_W-1:0] entry_count;

	modport source (output valid, slot, merged, appended, dropped, entry_red, entry_green,
		entry_blue, entry_count, input ready);
	modport sink (input valid, slot, merged, appended, dropped, entry_red, entry_green,
		entry_blue, entry_count, output ready);
endinterface

FILE: rtl/leader_color_clustering.sv
// Top level of the leader color clustering block: APB threshold register and the cell chain.
//
// Each table entry lives in a cell of a chain of TABLE_DEPTH cells. A request enters the first
// cell when accepted and moves one cell per clock while the chain advances, so one request is
// accepted every cycle unless the chain holds. Its result leaves the last of the TABLE_DEPTH
// registered cells, in request order. A request sees every entry exactly as the requests ahead
// of it left it, so match order is lowest slot first. When the result is not taken, the whole
// chain holds and the request side stalls with it. No clearing pass is needed after reset.
module leader_color_clustering import lcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	lcc_in_if.sink      samples,
	lcc_out_if.source   results,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic REG_THRESHOLD = 1'b0;

	logic [THR_W-1:0]  thr_q;
	logic [THR2_W-1:0] thr2_q;
	logic [THR_W-1:0]  wthr;
	logic              cfg_write;
	logic              advance;
	token_t            tok [0:TABLE_DEPTH];

	assign pready = 1'b1;
	assign wthr = pwdata[THR_W-1:0];
	assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_THRESHOLD);
	assign prdata = (paddr[2] == REG_THRESHOLD) ? {{(32 - THR_W){1'b0}}, thr_q} : 32'd0;

	// keep the squared radius ready so the cells compare against a register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_W'(THR_RESET);
			thr2_q <= THR2_W'(THR_RESET * THR_RESET);
		end else if (cfg_write) begin
			thr_q <= wthr;
			thr2_q <= THR2_W'(wthr) * THR2_W'(wthr);
		end
	end

	assign advance = !tok[TABLE_DEPTH].valid || results.ready;
	assign samples.ready = advance;

	always_comb begin
		tok[0] = '0;
		tok[0].valid = samples.valid;
		tok[0].op = samples.operation;
		tok[0].red = samples.red;
		tok[0].green = samples.green;
		tok[0].blue = samples.blue;
		tok[0].read_slot = samples.read_slot;
		if (samples.operation == OP_READ) begin
			tok[0].slot = SLOT_W'(samples.read_slot);
		end
	end

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		lcc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.index   (IDX_W'(i)),
			.thr2    (thr2_q),
			.tin     (tok[i]),
			.tout    (tok[i+1])
		);
	end

	assign results.valid = tok[TABLE_DEPTH].valid;
	assign results.slot = tok[TABLE_DEPTH].slot;
	assign results.merged = tok[TABLE_DEPTH].merged;
	assign results.appended = tok[TABLE_DEPTH].appended;
	assign results.dropped = (tok[TABLE_DEPTH].op == OP_CLUSTER) && !tok[TABLE_DEPTH].done;
	assign results.entry_red = tok[TABLE_DEPTH].res_red;
	assign results.entry_green = tok[TABLE_DEPTH].res_green;
	assign results.entry_blue = tok[TABLE_DEPTH].res_blue;
	assign results.entry_count = OUT_CNT_W'(tok[TABLE_DEPTH].count);

endmodule

FILE: rtl/lcc_cell.sv
// One table entry of the cluster chain: match, merge, append, read, clear and count for a passing request.
module lcc_cell import lcc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [IDX_W-1:0]  index,
	input  logic [THR2_W-1:0] thr2,
	input  token_t            tin,
	output token_t            tout
);

	logic [CH_W-1:0]   red_q;
	logic [CH_W-1:0]   green_q;
	logic [CH_W-1:0]   blue_q;
	logic              valid_q;

	logic [CH_W-1:0]   dr;
	logic [CH_W-1:0]   dg;
	logic [CH_W-1:0]   db;
	logic [THR2_W-1:0] d2;
	logic [CH_W:0]     sum_r;
	logic [CH_W:0]     sum_g;
	logic [CH_W:0]     sum_b;
	logic              hit;
	logic              append;
	logic              rd_hit;
	logic              valid_nxt;
	token_t            tnext;

	function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
		input logic [CH_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	always_comb begin
		dr = abs_diff(red_q, tin.red);
		dg = abs_diff(green_q, tin.green);
		db = abs_diff(blue_q, tin.blue);
		d2 = THR2_W'(dr) * THR2_W'(dr) + THR2_W'(dg) * THR2_W'(dg)
			+ THR2_W'(db) * THR2_W'(db);
		sum_r = {1'b0, red_q} + {1'b0, tin.red};
		sum_g = {1'b0, green_q} + {1'b0, tin.green};
		sum_b = {1'b0, blue_q} + {1'b0, tin.blue};
		hit = valid_q && !tin.done && (tin.op == OP_CLUSTER) && (d2 < thr2);
		// first free cell takes an unmatched sample; valid cells form a prefix
		append = !valid_q && !tin.done && (tin.op == OP_CLUSTER);
		rd_hit = valid_q && (tin.op == OP_READ) && (CMP_W'(index) == CMP_W'(tin.read_slot));
	end

	always_comb begin
		tnext = tin;
		valid_nxt = valid_q;
		if (tin.valid) begin
			if (tin.op == OP_CLEAR) begin
				valid_nxt = 1'b0;
			end else if (hit) begin
				tnext.done = 1'b1;
				tnext.merged = 1'b1;
				tnext.slot = SLOT_W'(index);
				tnext.res_red = sum_r[CH_W:1];
				tnext.res_green = sum_g[CH_W:1];
				tnext.res_blue = sum_b[CH_W:1];
			end else if (append) begin
				valid_nxt = 1'b1;
				tnext.done = 1'b1;
				tnext.appended = 1'b1;
				tnext.slot = SLOT_W'(index);
				tnext.res_red = tin.red;
				tnext.res_green = tin.green;
				tnext.res_blue = tin.blue;
			end else if (rd_hit) begin
				tnext.res_red = red_q;
				tnext.res_green = green_q;
				tnext.res_blue = blue_q;
			end
			tnext.count = tin.count + CNT_W'(valid_nxt);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tout <= '0;
			valid_q <= 1'b0;
		end else if (advance) begin
			tout <= tnext;
			if (tin.valid) begin
				valid_q <= valid_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && tin.valid && (hit || append)) begin
			red_q <= tnext.res_red;
			green_q <= tnext.res_green;
			blue_q <= tnext.res_blue;
		end
	end

endmodule
